// File: sv/tccs_pkg.sv
`default_nettype none
package tccs_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // configuration register indexes
  localparam logic CFG_BACKGROUND = 1'b0;
  localparam logic CFG_FOREGROUND = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT_CHAR   = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_CELL  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic write_char;
    logic advance;
    logic set_cursor;
    logic sweep_start;
    logic clear_step;
    logic scroll_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic scroll_needed;
    logic clear_done;
    logic scroll_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/tccs_ctrl.sv
`default_nettype none
module tccs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tccs_pkg::sts_t sts,
  output tccs_pkg::cmd_t     cmd
);
  import tccs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_PUT_CHAR: begin
            cmd.write_char = 1'b1;
            cmd.advance    = 1'b1;
            if (sts.scroll_needed) begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_SCROLL;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          OP_SET_CURSOR: begin
            cmd.set_cursor = 1'b1;
            state_nxt      = ST_DONE;
          end
          OP_CLEAR: begin
            cmd.sweep_start = 1'b1;
            state_nxt       = ST_CLEAR;
          end
          OP_READ_CELL: begin
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.scroll_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/tccs_datapath.sv
`default_nettype none
module tccs_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tccs_pkg::in_item_t  in_item,
  input  wire tccs_pkg::cmd_t      cmd,
  output tccs_pkg::sts_t           sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tccs_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [3:0]          cfg_wdata
);
  import tccs_pkg::*;

  localparam int TOTAL  = COLUMNS * ROWS;
  localparam int N_COPY = COLUMNS * (ROWS - 1);
  localparam int ADDR_W = $clog2(TOTAL);
  localparam int CNT_W  = $clog2(TOTAL + 1);
  localparam logic [6:0] COL_MAX = 7'(COLUMNS - 1);
  localparam logic [4:0] ROW_MAX = 5'(ROWS - 1);

  logic [15:0] mem [TOTAL];

  logic [3:0]       bg_color_r, fg_color_r;
  logic [6:0]       col_r, col_nxt;
  logic [4:0]       row_r, row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  op_t              op_r;
  logic             nl_r;
  logic [7:0]       char_r;
  logic [6:0]       pos_x_r;
  logic [4:0]       pos_y_r;
  logic [15:0]      rd_q_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic [6:0]        sat_x;
  logic [4:0]        sat_y;
  logic [ADDR_W-1:0] cur_addr, item_addr, rd_addr, wr_addr;
  logic [15:0]       wr_data;
  logic              mem_we;
  logic              col_last, row_last;
  logic [CNT_W-1:0]  cnt_m1;

  assign sat_x = (in_item.pos_x > COL_MAX) ? COL_MAX : in_item.pos_x;
  assign sat_y = (in_item.pos_y > ROW_MAX) ? ROW_MAX : in_item.pos_y;

  assign cur_addr  = ADDR_W'(32'(row_r) * COLUMNS + 32'(col_r));
  assign item_addr = ADDR_W'(32'(pos_y_r) * COLUMNS + 32'(pos_x_r));
  assign col_last  = (col_r == COL_MAX);
  assign row_last  = (row_r == ROW_MAX);
  assign cnt_m1    = cnt_r - CNT_W'(1);

  // read source: the row below during scroll, else the held item position
  always_comb begin
    if (cmd.scroll_step && (cnt_r < CNT_W'(N_COPY))) begin
      rd_addr = ADDR_W'(32'(cnt_r) + COLUMNS);
    end else begin
      rd_addr = item_addr;
    end
  end

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = cur_addr;
    wr_data = {bg_color_r, fg_color_r, char_r};
    if (cmd.clear_step) begin
      mem_we  = 1'b1;
      wr_addr = cnt_r[ADDR_W-1:0];
      wr_data = '0;
    end else if (cmd.scroll_step) begin
      // write one behind the read; blank the bottom row
      mem_we  = (cnt_r != '0);
      wr_addr = cnt_m1[ADDR_W-1:0];
      wr_data = (cnt_r <= CNT_W'(N_COPY)) ? rd_q_r : 16'h0000;
    end else if (cmd.write_char) begin
      mem_we = !nl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (cmd.set_cursor) begin
      col_nxt = pos_x_r;
      row_nxt = pos_y_r;
    end else if (cmd.advance) begin
      if (nl_r || col_last) begin
        col_nxt = '0;
        if (!row_last) begin
          row_nxt = row_r + 5'd1;
        end
      end else begin
        col_nxt = col_r + 7'd1;
      end
    end
    if (cmd.sweep_start) begin
      cnt_nxt = '0;
    end else if (cmd.clear_step || cmd.scroll_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_color_r  <= '0;
      fg_color_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BACKGROUND) begin
          bg_color_r <= cfg_wdata;
        end else begin
          fg_color_r <= cfg_wdata;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.op;
      nl_r    <= (in_item.char_code == NEWLINE_CODE);
      char_r  <= in_item.char_code;
      pos_x_r <= sat_x;
      pos_y_r <= sat_y;
    end
    if (cmd.out_load) begin
      out_item_r.cell_value <= (op_r == OP_READ_CELL) ? rd_q_r : 16'h0000;
      out_item_r.cursor_col <= col_r;
      out_item_r.cursor_row <= row_r;
    end
  end

  assign sts.op            = op_r;
  assign sts.scroll_needed = row_last && (nl_r || col_last);
  assign sts.clear_done    = (cnt_r == CNT_W'(TOTAL - 1));
  assign sts.scroll_done   = (cnt_r == CNT_W'(TOTAL));
  assign sts.out_busy      = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: sv/text_console_cursor_scroll.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    tccs_pkg::in_item_t (op, char, x, y)
// out_      output     out_valid / out_ready  tccs_pkg::out_item_t (cell, cursor)
// cfg_      input      cfg_we                 cfg_index selects color, cfg_wdata
//
// A put, set-cursor or read transaction runs from acceptance to result through the
// controller's states in order (accept, execute, load the output register); the
// screen memory read is registered.
// A clear or a scroll adds a sweep of the whole screen memory, one cell per cycle
// through its single write port.
// After reset a clearing pass over the whole screen runs with in_ready low;
// configuration writes are taken throughout.
// The output register holds a result while out_ready is low; the next transaction
// is accepted meanwhile and waits at its end until the register frees up.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tccs_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tccs_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [3:0]          cfg_wdata
);
  import tccs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence each transaction: execute, sweep for clear or scroll, deliver
  tccs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold cursor, colors, screen memory and the output register
  tccs_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

// File: sv/tccs_checker.sv
`default_nettype none
module tccs_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tccs_pkg::out_item_t out_item
);

  // cursor stays on the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.cursor_col) < COLUMNS))
    else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.cursor_row) < ROWS))
    else $error("cursor row off screen");

  // one transaction at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transaction accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result dropped or changed");

endmodule

bind text_console_cursor_scroll tccs_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
